// ----- rtl/core/fimorph_pkg.sv -----
// Package of the flag image 3x3 morphology block.
// Holds widths, flag masks, register and mode codes and the structs that travel
// between the block's modules. Depends on nothing.
package fimorph_pkg;

  localparam int unsigned MaxWidthDef = 1024;

  localparam int unsigned FlagW     = 6;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned HeightW   = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned OutDepth = 4;
  localparam int unsigned LvlW     = $clog2(OutDepth + 1);

  localparam logic [FlagW-1:0] FlSolid    = 6'h01;
  localparam logic [FlagW-1:0] FlDilated  = 6'h02;
  localparam logic [FlagW-1:0] FlBoundary = 6'h04;
  localparam logic [FlagW-1:0] FlBand     = 6'h08;
  localparam logic [FlagW-1:0] FlNoHole   = 6'h10;

  typedef enum logic [1:0] {
    ModeDilate   = 2'd0,
    ModeBand     = 2'd1,
    ModeBoundary = 2'd2,
    ModeClose    = 2'd3
  } pass_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1,
    RegPassMode    = 2'd2,
    RegBorderFlags = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_mask_t;

  typedef struct packed {
    logic             adv;
    logic             emit;
    logic             frame_end;
    logic [FlagW-1:0] pix;
    edge_mask_t       mask;
    pass_mode_e       mode;
    logic [FlagW-1:0] border;
  } step_t;

  typedef struct packed {
    logic [FlagW-1:0] result_flags;
    logic             frame_end;
  } result_t;

endpackage

// ----- rtl/core/fimorph_if.sv -----
// Handshake interfaces of the flag image 3x3 morphology block.
// One carries incoming pixel words, the other result words; both use fimorph_pkg.
interface fimorph_in_if;
  import fimorph_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [FlagW-1:0] pixel_flags;

  modport source (output valid, command, pixel_flags, input ready);
  modport sink (input valid, command, pixel_flags, output ready);
endinterface

interface fimorph_out_if;
  import fimorph_pkg::*;

  logic             valid;
  logic             ready;
  logic [FlagW-1:0] result_flags;
  logic             frame_end;

  modport source (output valid, result_flags, frame_end, input ready);
  modport sink (input valid, result_flags, frame_end, output ready);
endinterface

// ----- rtl/core/flag_image_3x3_morphology.sv -----
// Top level of the streaming 3x3 flag image morphology block.
// Built from fimorph_ctrl, fimorph_window and fimorph_out_fifo; uses fimorph_pkg.
//
// Usage: pixel words enter on in_i in raster order (command 0), flush words
// (command 1) drain the results still owed once the whole frame has arrived.
// A word is taken when valid and ready are both high. Results leave on out_o
// with frame_end set on the frame's last pixel. The configuration port writes
// frame_width, frame_height, pass_mode and border_flags; a geometry write
// restarts the frame. Write it only while no result is outstanding.
// Throughput is one word per cycle while ready stays high, set by the window
// step and the two line store RAMs, which each do one read and one write per
// cycle. A one-row frame takes one extra step, with ready low, after its last
// pixel. A result passes step registers s1 and s2 and the output queue before
// it is shown; it lags its pixel by one row plus one pixel of input words.
// When the receiver stalls, up to four results wait in the output queue and
// ready drops once the queue plus results in flight would fill it.
// Reset clears all counters and the window, sets the configuration to its
// defaults and needs no clearing pass; the block is ready right after reset.
module flag_image_3x3_morphology #(
  parameter int unsigned MAX_WIDTH = fimorph_pkg::MaxWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  fimorph_in_if.sink                        in_i,
  fimorph_out_if.source                     out_o,
  input  logic                              cfg_we_i,
  input  logic [fimorph_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fimorph_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import fimorph_pkg::*;

  step_t                          step;
  logic [$clog2(MAX_WIDTH)-1:0]   step_addr;
  logic                           res_valid;
  result_t                        res;
  result_t                        out_data;
  logic [1:0]                     inflight;
  logic [LvlW-1:0]                level;
  logic                           credit_ok;
  logic                           pop;

  assign credit_ok = ((LvlW + 1)'(level) + (LvlW + 1)'(inflight)) < (LvlW + 1)'(OutDepth);
  assign pop       = out_o.valid && out_o.ready;

  fimorph_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_command_i(in_i.command),
    .in_pixel_i  (in_i.pixel_flags),
    .credit_ok_i (credit_ok),
    .in_ready_o  (in_i.ready),
    .step_o      (step),
    .step_addr_o (step_addr)
  );

  fimorph_window #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .step_addr_i(step_addr),
    .res_valid_o(res_valid),
    .res_o      (res),
    .inflight_o (inflight)
  );

  fimorph_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .pop_i      (pop),
    .valid_o    (out_o.valid),
    .data_o     (out_data),
    .level_o    (level)
  );

  assign out_o.result_flags = out_data.result_flags;
  assign out_o.frame_end    = out_data.frame_end;

endmodule

// ----- rtl/core/fimorph_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents. No dependencies.
module fimorph_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/fimorph_ctrl.sv -----
// Control of the flag image morphology block: configuration registers, raster
// and result position counters, pending count and input flow control.
// Uses fimorph_pkg; issues one step per advancing word, and the extra step of a one-row frame, to fimorph_window.
module fimorph_ctrl #(
  parameter int unsigned MAX_WIDTH = fimorph_pkg::MaxWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fimorph_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [fimorph_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_command_i,
  input  logic [fimorph_pkg::FlagW-1:0]       in_pixel_i,
  input  logic                                credit_ok_i,
  output logic                                in_ready_o,
  output fimorph_pkg::step_t                  step_o,
  output logic [$clog2(MAX_WIDTH)-1:0]        step_addr_o
);
  import fimorph_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);

  logic [WidthRegW-1:0] width_q;
  logic [HeightW-1:0]   height_q;
  pass_mode_e           mode_q;
  logic [FlagW-1:0]     border_q;

  logic [CW-1:0]      col_q, col_d;
  logic [HeightW-1:0] row_q, row_d;
  logic [PW-1:0]      pend_q, pend_d;
  logic [CW-1:0]      ecol_q, ecol_d;
  logic [HeightW-1:0] erow_q, erow_d;
  logic               extra_q, extra_d;

  logic [WW-1:0]      w_eff;
  logic [CW-1:0]      w_last;
  logic [PW-1:0]      w_plus1;
  logic [HeightW-1:0] h_eff;
  logic [HeightW-1:0] h_last;

  logic accept, complete, is_pix, is_flush, adv, emit, fend;
  logic pend_full, col_wrap, ecol_wrap, last_pix, geom_write;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_q) > int'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
  end

  assign w_last  = CW'(w_eff - WW'(1));
  assign w_plus1 = PW'(w_eff) + PW'(1);
  assign h_eff   = (height_q == '0) ? HeightW'(1) : height_q;
  assign h_last  = h_eff - HeightW'(1);

  assign in_ready_o = credit_ok_i && !extra_q;
  assign accept     = in_valid_i && in_ready_o;
  assign complete   = (row_q >= h_eff);
  assign is_pix     = accept && !in_command_i && !complete;
  assign is_flush   = accept && complete && (pend_q != '0);
  assign pend_full  = (pend_q == w_plus1);
  assign col_wrap   = (col_q == w_last);
  assign ecol_wrap  = (ecol_q == w_last);
  assign last_pix   = is_pix && col_wrap && (row_q == h_last);
  assign adv        = is_pix || is_flush || extra_q;
  assign emit       = (is_pix && pend_full) || is_flush;
  assign fend       = is_flush && (pend_q == PW'(1));
  assign geom_write = cfg_we_i && ((cfg_idx_i == RegFrameWidth) ||
                                   (cfg_idx_i == RegFrameHeight));

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    pend_d  = pend_q;
    ecol_d  = ecol_q;
    erow_d  = erow_q;
    extra_d = 1'b0;
    if (adv) begin
      col_d = col_wrap ? '0 : col_q + CW'(1);
    end
    if (is_pix && col_wrap) begin
      row_d = row_q + HeightW'(1);
    end
    if (is_pix && !pend_full) begin
      pend_d = pend_q + PW'(1);
    end
    if (is_flush) begin
      pend_d = pend_q - PW'(1);
    end
    if (emit) begin
      ecol_d = ecol_wrap ? '0 : ecol_q + CW'(1);
      if (ecol_wrap) begin
        erow_d = erow_q + HeightW'(1);
      end
    end
    // A one-row frame ends one column short of the usual window lag, so one
    // extra step without a result is slipped in behind its last pixel.
    if (last_pix && !pend_full && ((pend_q + PW'(1)) != w_plus1)) begin
      extra_d = 1'b1;
    end
    if (fend || geom_write) begin
      col_d   = '0;
      row_d   = '0;
      pend_d  = '0;
      ecol_d  = '0;
      erow_d  = '0;
      extra_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRegW'(1024);
      height_q <= HeightW'(1024);
      mode_q   <= ModeDilate;
      border_q <= '0;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      ecol_q   <= '0;
      erow_q   <= '0;
      extra_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      ecol_q  <= ecol_d;
      erow_q  <= erow_d;
      extra_q <= extra_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFrameWidth:  width_q  <= cfg_wdata_i[WidthRegW-1:0];
          RegFrameHeight: height_q <= cfg_wdata_i[HeightW-1:0];
          RegPassMode:    mode_q   <= pass_mode_e'(cfg_wdata_i[1:0]);
          RegBorderFlags: border_q <= cfg_wdata_i[FlagW-1:0];
          default:        border_q <= border_q;
        endcase
      end
    end
  end

  always_comb begin
    step_o.adv         = adv;
    step_o.emit        = emit;
    step_o.frame_end   = fend;
    step_o.pix         = is_pix ? in_pixel_i : border_q;
    step_o.mask.left   = (ecol_q == '0);
    step_o.mask.right  = ecol_wrap;
    step_o.mask.top    = (erow_q == '0);
    step_o.mask.bottom = (erow_q == h_last);
    step_o.mode        = mode_q;
    step_o.border      = border_q;
  end

  assign step_addr_o = col_q;

endmodule

// ----- rtl/core/fimorph_window.sv -----
// Line stores, 3x3 window and per-mode flag update of the morphology block.
// Uses fimorph_pkg and two fimorph_ram instances; steps come from fimorph_ctrl.
module fimorph_window #(
  parameter int unsigned MAX_WIDTH = fimorph_pkg::MaxWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fimorph_pkg::step_t            step_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  step_addr_i,
  output logic                          res_valid_o,
  output fimorph_pkg::result_t          res_o,
  output logic [1:0]                    inflight_o
);
  import fimorph_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  step_t            s1_q, s2_q;
  logic [CW-1:0]    addr1_q;
  logic [FlagW-1:0] line1_rd, line2_rd, mid_q;

  logic [2:0][2:0][FlagW-1:0] win_q, win_d, nb;
  logic [FlagW-1:0]           res_flags;

  function automatic logic [FlagW-1:0] morph_eval(input pass_mode_e mode,
                                                  input logic [2:0][2:0][FlagW-1:0] n);
    logic [FlagW-1:0] here, sd, res;
    logic             any_sd, any_bsd, full, empty;
    here    = n[1][1];
    sd      = FlSolid | FlDilated;
    res     = here;
    any_sd  = 1'b0;
    any_bsd = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        any_sd  = any_sd | (|(n[r][c] & sd));
        any_bsd = any_bsd | (|(n[r][c] & (sd | FlBand)));
      end
    end
    full  = (|(n[1][0] & sd)) || (|(n[1][2] & sd)) ||
            (|(n[0][1] & sd)) || (|(n[2][1] & sd));
    empty = !(|(n[1][0] & sd)) || !(|(n[1][2] & sd)) ||
            !(|(n[0][1] & sd)) || !(|(n[2][1] & sd));
    case (mode)
      ModeDilate: begin
        if (!(|(here & sd)) && any_sd) res = here | FlDilated;
      end
      ModeBand: begin
        if (|(here & FlSolid)) res = here;
        else if (|(here & FlDilated)) res = here | FlBand;
        else if (any_bsd) res = here | FlBand;
      end
      ModeBoundary: begin
        if ((|(here & sd)) && full && empty) res = here | FlBoundary;
      end
      ModeClose: begin
        if (!(|(here & (sd | FlNoHole)))) res = here | FlDilated;
      end
      default: res = here;
    endcase
    return res;
  endfunction

  // The first store delays a column by one row, the second by a further row.
  fimorph_ram #(
    .Width(FlagW),
    .Depth(MAX_WIDTH)
  ) u_line1 (
    .clk_i  (clk_i),
    .we_i   (step_i.adv),
    .waddr_i(step_addr_i),
    .wdata_i(step_i.pix),
    .raddr_i(step_addr_i),
    .rdata_o(line1_rd)
  );

  fimorph_ram #(
    .Width(FlagW),
    .Depth(MAX_WIDTH)
  ) u_line2 (
    .clk_i  (clk_i),
    .we_i   (s1_q.adv),
    .waddr_i(addr1_q),
    .wdata_i(line1_rd),
    .raddr_i(addr1_q),
    .rdata_o(line2_rd)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = line2_rd;
    win_d[1][2] = mid_q;
    win_d[2][2] = s2_q.pix;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((c == 0 && s2_q.mask.left) || (c == 2 && s2_q.mask.right) ||
            (r == 0 && s2_q.mask.top) || (r == 2 && s2_q.mask.bottom)) begin
          nb[r][c] = s2_q.border;
        end else begin
          nb[r][c] = win_d[r][c];
        end
      end
    end
  end

  assign res_flags = morph_eval(s2_q.mode, nb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      win_q <= '0;
    end else begin
      s1_q <= step_i;
      s2_q <= s1_q;
      if (s2_q.adv) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= step_addr_i;
    mid_q   <= line1_rd;
  end

  assign res_valid_o        = s2_q.emit;
  assign res_o.result_flags = res_flags;
  assign res_o.frame_end    = s2_q.frame_end;
  assign inflight_o         = 2'(s1_q.emit) + 2'(s2_q.emit);

endmodule

// ----- rtl/core/fimorph_out_fifo.sv -----
// Result queue of the morphology block: a small register FIFO in front of the
// output channel that absorbs results still in flight when the receiver stalls.
// Uses fimorph_pkg.
module fimorph_out_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  fimorph_pkg::result_t           push_data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output fimorph_pkg::result_t           data_o,
  output logic [fimorph_pkg::LvlW-1:0]   level_o
);
  import fimorph_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);

  result_t         mem_q [OutDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [LvlW-1:0] level_q, level_d;

  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) level_d = level_q + LvlW'(1);
    if (!push_i && pop_i) level_d = level_q - LvlW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) wptr_q <= wptr_q + PtrW'(1);
      if (pop_i)  rptr_q <= rptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign level_o = level_q;

endmodule

// ----- rtl/core/fimorph_checker.sv -----
// Port-level checks of the flag image 3x3 morphology block over time.
// Bound to flag_image_3x3_morphology; uses fimorph_pkg for the flag width.
module fimorph_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [fimorph_pkg::FlagW-1:0]  out_flags_i,
  input logic                           out_frame_end_i
);
  import fimorph_pkg::*;

  logic in_accept;
  assign in_accept = in_valid_i && in_ready_i;

  // A stalled result word stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word withdrawn while stalled");

  // A stalled result word keeps its payload.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_flags_i) && $stable(out_frame_end_i))
    else $error("result payload changed while stalled");

  // A result can only appear once the word that caused it has passed the pipeline.
  a_out_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_accept, 3))
    else $error("result appeared without a word taken three cycles earlier");

endmodule

bind flag_image_3x3_morphology fimorph_checker u_fimorph_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_flags_i    (out_o.result_flags),
  .out_frame_end_i(out_o.frame_end)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of flag_image_3x3_morphology. Words are driven and collected
// over fimorph_in_if and fimorph_out_if and checked against a predictor of the 3x3 window.
// Depends on fimorph_pkg, the handshake interfaces and the block itself.
module testbench;
  import fimorph_pkg::*;

  localparam int unsigned HistDepth    = 2 * MaxWidthDef + 4;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomWords  = 1650;

  typedef enum logic {
    CmdPixel = 1'b0,
    CmdFlush = 1'b1
  } command_e;

  typedef struct packed {
    command_e         cmd;
    logic [FlagW-1:0] pix;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  fimorph_in_if pix_if ();
  fimorph_out_if res_if ();

  flag_image_3x3_morphology DUT (
    .clk_i,
    .rst_ni,
    .in_i(pix_if),
    .out_o(res_if),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  logic [FlagW-1:0] line_hist [HistDepth];
  logic [WidthRegW-1:0] width_reg;
  logic [HeightW-1:0] height_reg;
  pass_mode_e mode_reg;
  logic [FlagW-1:0] border_reg;
  int unsigned col_pos, row_pos, unanswered;

  result_t owed_results[$];
  word_t pending_words[$];
  int unsigned words_queued, words_taken, fail_count, cycle_count, random_words;
  int unsigned in_idle_pct, out_idle_pct;
  int unsigned hold_requests, holds_served, hold_left;
  logic word_taken;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned span_w();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidthDef) return MaxWidthDef;
    return width_reg;
  endfunction

  function automatic int unsigned span_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_raster();
    col_pos = 0;
    row_pos = 0;
    unanswered = 0;
  endfunction

  function automatic void morph_result(int unsigned c, int unsigned w, int unsigned h);
    logic [FlagW-1:0] nb [9];
    logic [FlagW-1:0] centre, flags, occupied;
    int dy, dx, nc, nr, k;
    longint li;
    int unsigned full, hollow;
    result_t r;
    occupied = FlSolid | FlDilated;
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        nc = int'(c % w) + dx;
        nr = int'(c / w) + dy;
        if (nc < 0 || nc >= int'(w) || nr < 0 || nr >= int'(h)) begin
          nb[(dy + 1) * 3 + dx + 1] = border_reg;
        end else begin
          li = longint'(c) + longint'(dy) * longint'(w) + longint'(dx);
          nb[(dy + 1) * 3 + dx + 1] = line_hist[li % HistDepth];
        end
      end
    end
    centre = nb[4];
    flags = centre;
    case (mode_reg)
      ModeDilate: begin
        if ((centre & occupied) == 0)
          for (k = 0; k < 9; k++) if ((nb[k] & occupied) != 0) flags = centre | FlDilated;
      end
      ModeBand: begin
        if ((centre & FlSolid) != 0) flags = centre;
        else if ((centre & FlDilated) != 0) flags = centre | FlBand;
        else
          for (k = 0; k < 9; k++)
            if ((nb[k] & (occupied | FlBand)) != 0) flags = centre | FlBand;
      end
      ModeBoundary: begin
        if ((centre & occupied) != 0) begin
          full = 0;
          hollow = 0;
          // The edge neighbors (left, right, top and bottom) sit at the odd window positions.
          for (k = 1; k < 9; k += 2) begin
            if ((nb[k] & occupied) != 0) full++;
            else hollow++;
          end
          if (full != 0 && hollow != 0) flags = centre | FlBoundary;
        end
      end
      ModeClose: begin
        if ((centre & (occupied | FlNoHole)) == 0) flags = centre | FlDilated;
      end
    endcase
    if (unanswered > 0) unanswered--;
    r.result_flags = flags;
    r.frame_end = (c == w * h - 1);
    owed_results = {owed_results, r};
    if (r.frame_end) restart_raster();
  endfunction

  function automatic void absorb_word(word_t wd);
    int unsigned w, h, idx;
    w = span_w();
    h = span_h();
    if (wd.cmd == CmdPixel && row_pos < h) begin
      idx = row_pos * w + col_pos;
      line_hist[idx % HistDepth] = wd.pix;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      unanswered++;
      if (unanswered > w + 1) morph_result(idx + 1 - unanswered, w, h);
    end else if (row_pos >= h && unanswered != 0) begin
      morph_result(row_pos * w + col_pos - unanswered, w, h);
    end
  endfunction

  always @(posedge clk_i) begin : word_monitor
    result_t want;
    if (rst_ni) begin
      cycle_count++;
      if (res_if.valid && res_if.ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: result_flags %h frame_end %b",
                 res_if.result_flags, res_if.frame_end);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (res_if.result_flags !== want.result_flags) begin
            $error("result_flags: expected %h, got %h", want.result_flags, res_if.result_flags);
            fail_count++;
          end
          if (res_if.frame_end !== want.frame_end) begin
            $error("frame_end: expected %b, got %b", want.frame_end, res_if.frame_end);
            fail_count++;
          end
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        absorb_word('{cmd: command_e'(pix_if.command), pix: pix_if.pixel_flags});
        words_taken++;
        word_taken = 1'b1;
      end
      if (cycle_count > CycleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : word_driver
    word_t nxt;
    logic offer;
    if (rst_ni && (!pix_if.valid || word_taken)) begin
      word_taken = 1'b0;
      offer = (pending_words.size() != 0) && ($urandom_range(99) >= in_idle_pct);
      if (offer) begin
        nxt = pending_words.pop_front();
        pix_if.command <= nxt.cmd;
        pix_if.pixel_flags <= nxt.pix;
      end
      pix_if.valid <= offer;
    end
  end

  always @(negedge clk_i) begin : result_receiver
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HoldCycles;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic write_reg(cfg_reg_e r, logic [CfgDataW-1:0] v);
    case (r)
      RegFrameWidth: begin
        width_reg = v[WidthRegW-1:0];
        restart_raster();
      end
      RegFrameHeight: begin
        height_reg = v[HeightW-1:0];
        restart_raster();
      end
      RegPassMode: mode_reg = pass_mode_e'(v[1:0]);
      RegBorderFlags: border_reg = v[FlagW-1:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgDataW-1:0] with_spare_bits(logic [CfgDataW-1:0] v,
                                                           int unsigned used);
    logic [CfgDataW-1:0] junk;
    junk = CfgDataW'($urandom);
    if ($urandom_range(3) != 0) return v;
    return (junk << used) | v;
  endfunction

  function automatic logic [FlagW-1:0] rand_flags(logic sparse);
    logic [FlagW-1:0] f;
    f = FlagW'($urandom);
    if (sparse && $urandom_range(3) != 0) f = f & ~(FlSolid | FlDilated);
    return f;
  endfunction

  task automatic queue_word(command_e c, logic [FlagW-1:0] p);
    word_t wd;
    wd.cmd = c;
    wd.pix = p;
    pending_words = {pending_words, wd};
    words_queued++;
  endtask

  task automatic queue_frame(int unsigned w, int unsigned h, logic sparse, logic cut);
    int unsigned total, fed, drain, i;
    total = w * h;
    fed = cut ? $urandom_range(total - 1) : total;
    for (i = 0; i < fed; i++) begin
      if ($urandom_range(24) == 0) queue_word(CmdFlush, rand_flags(sparse));
      queue_word(CmdPixel, rand_flags(sparse));
    end
    random_words += fed;
    if (!cut) begin
      drain = (total < w + 1) ? total : w + 1;
      for (i = 0; i < drain; i++)
        queue_word(($urandom_range(7) == 0) ? CmdPixel : CmdFlush, rand_flags(sparse));
      random_words += drain;
      if ($urandom_range(5) == 0) queue_word(CmdFlush, rand_flags(sparse));
    end
  endtask

  task automatic settle();
    while (!(pending_words.size() == 0 && words_taken == words_queued &&
             owed_results.size() == 0))
      @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase, frames, f, i, w_val, h_val;
    logic sparse;
    pix_if.valid = 1'b0;
    pix_if.command = CmdPixel;
    pix_if.pixel_flags = '0;
    res_if.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegFrameWidth;
    cfg_wdata_i = '0;
    word_taken = 1'b0;
    words_queued = 0;
    words_taken = 0;
    fail_count = 0;
    cycle_count = 0;
    random_words = 0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    in_idle_pct = 36;
    out_idle_pct = 36;
    width_reg = WidthRegW'(MaxWidthDef);
    height_reg = 16'd1024;
    mode_reg = ModeDilate;
    border_reg = '0;
    foreach (line_hist[j]) line_hist[j] = '0;
    restart_raster();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Dilate on a 3x2 frame with an early flush and a pixel word arriving after the frame.
    write_reg(RegFrameWidth, 16'd3);
    write_reg(RegFrameHeight, 16'd2);
    write_reg(RegPassMode, CfgDataW'(ModeDilate));
    write_reg(RegBorderFlags, 16'd0);
    queue_word(CmdPixel, 6'h00);
    queue_word(CmdFlush, 6'h00);
    queue_word(CmdPixel, 6'h3F);
    queue_word(CmdPixel, 6'h01);
    queue_word(CmdPixel, 6'h02);
    queue_word(CmdPixel, 6'h3E);
    queue_word(CmdPixel, 6'h20);
    queue_word(CmdFlush, 6'h00);
    queue_word(CmdPixel, 6'h15);
    queue_word(CmdFlush, 6'h00);
    queue_word(CmdFlush, 6'h00);
    queue_word(CmdFlush, 6'h00);
    settle();

    // Zero width and zero height act as a single pixel; full border in boundary mode.
    write_reg(RegFrameWidth, 16'd0);
    write_reg(RegFrameHeight, 16'd0);
    write_reg(RegPassMode, CfgDataW'(ModeBoundary));
    write_reg(RegBorderFlags, 16'h003F);
    queue_word(CmdPixel, 6'h01);
    queue_word(CmdFlush, 6'h00);
    settle();

    write_reg(RegFrameWidth, 16'd2);
    write_reg(RegFrameHeight, 16'd1);
    write_reg(RegPassMode, CfgDataW'(ModeBand));
    write_reg(RegBorderFlags, 16'd0);
    queue_word(CmdPixel, 6'h08);
    queue_word(CmdPixel, 6'h00);
    queue_word(CmdFlush, 6'h00);
    queue_word(CmdFlush, 6'h00);
    settle();

    write_reg(RegFrameWidth, 16'd1);
    write_reg(RegFrameHeight, 16'd3);
    write_reg(RegPassMode, CfgDataW'(ModeClose));
    write_reg(RegBorderFlags, 16'h0015);
    queue_word(CmdPixel, 6'h00);
    queue_word(CmdPixel, 6'h10);
    queue_word(CmdPixel, 6'h04);
    queue_word(CmdFlush, 6'h00);
    queue_word(CmdFlush, 6'h00);

    phase = 0;
    while (random_words < RandomWords || phase <= 5) begin
      settle();
      in_idle_pct = 36;
      out_idle_pct = 36;
      sparse = 1'($urandom_range(1));
      if (phase == 1) begin
        // The receiver holds off while the sender keeps the input full.
        in_idle_pct = 0;
        write_reg(RegFrameWidth, 16'd4);
        write_reg(RegFrameHeight, 16'd30);
        write_reg(RegPassMode, CfgDataW'($urandom_range(3)));
        hold_requests++;
        queue_frame(4, 30, sparse, 1'b0);
      end else if (phase == 3) begin
        // Oversized width clamps to the widest row; the frame is left unfinished.
        write_reg(RegFrameWidth, 16'h07FF);
        write_reg(RegFrameHeight, 16'hFFFF);
        write_reg(RegPassMode, CfgDataW'($urandom_range(3)));
        write_reg(RegBorderFlags, CfgDataW'($urandom_range(63)));
        for (i = 0; i < MaxWidthDef + 4; i++) queue_word(CmdPixel, rand_flags(1'b1));
        random_words += MaxWidthDef + 4;
      end else if (phase == 5) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
        write_reg(RegFrameWidth, 16'd7);
        write_reg(RegFrameHeight, 16'd9);
        for (f = 0; f < 3; f++) queue_frame(7, 9, sparse, 1'b0);
      end else begin
        w_val = ($urandom_range(4) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        if ($urandom_range(9) == 0) w_val = 0;
        h_val = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
        write_reg(RegFrameWidth, with_spare_bits(CfgDataW'(w_val), WidthRegW));
        write_reg(RegFrameHeight, CfgDataW'(h_val));
        if ($urandom_range(1) == 1)
          write_reg(RegPassMode, with_spare_bits(CfgDataW'($urandom_range(3)), 2));
        if ($urandom_range(1) == 1)
          write_reg(RegBorderFlags, with_spare_bits(CfgDataW'($urandom_range(63)), FlagW));
        frames = $urandom_range(3, 1);
        for (f = 0; f < frames; f++)
          queue_frame(span_w(), span_h(), sparse, (f == frames - 1) && ($urandom_range(5) == 0));
      end
      phase++;
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
